[rtl/core/hfa_pkg.sv]
// Package for the hole fit allocator: size defaults, field widths, policy and
// action codes, controller state type, and the controller/datapath structs.
// No dependencies.
package hfa_pkg;

  localparam int NUM_HOLES_DEF = 8;
  localparam int SIZE_BITS_DEF = 16;
  localparam int INDEX_BITS    = 3;
  localparam int POLICY_BITS   = 2;

  // fit policy codes; the spare code behaves as first fit
  localparam logic [POLICY_BITS-1:0] FIT_FIRST = 2'd0;
  localparam logic [POLICY_BITS-1:0] FIT_BEST  = 2'd1;
  localparam logic [POLICY_BITS-1:0] FIT_WORST = 2'd2;

  // action codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_ALLOC = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic idle;    // input may be taken
    logic scan;    // issue table read for current count
    logic commit;  // write table, load output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_alloc;
    logic scan_last;
    logic out_free;
  } ctrl_stat_t;

endpackage

[rtl/core/hfa_ifs.sv]
// Channel interfaces of the hole fit allocator: request, result and policy
// configuration. Depends on hfa_pkg.
interface hfa_in_if #(
  parameter int SIZE_BITS = hfa_pkg::SIZE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [hfa_pkg::INDEX_BITS-1:0] hole_index;
  logic [SIZE_BITS-1:0]         size_value;

  modport source (output valid, action, hole_index, size_value, input ready);
  modport sink   (input valid, action, hole_index, size_value, output ready);
endinterface

interface hfa_out_if #(
  parameter int SIZE_BITS = hfa_pkg::SIZE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         granted;
  logic [hfa_pkg::INDEX_BITS-1:0] chosen_index;
  logic [SIZE_BITS-1:0]         remaining;

  modport source (output valid, granted, chosen_index, remaining, input ready);
  modport sink   (input valid, granted, chosen_index, remaining, output ready);
endinterface

interface hfa_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [hfa_pkg::POLICY_BITS-1:0] fit_policy;

  modport source (output valid, fit_policy, input ready);
  modport sink   (input valid, fit_policy, output ready);
endinterface

[rtl/core/hole_fit_allocator_unit.sv]
// Hole fit allocator, top level: controller plus datapath.
// Depends on hfa_pkg, hfa_ifs, hfa_ram, hfa_ctrl and hfa_datapath.
//
// Keeps a table of NUM_HOLES free hole sizes. Each transaction on alloc_in
// either loads one hole size (action load) or requests an allocation of
// size_value (action allocate). Every input transaction yields exactly one
// transaction on alloc_out: loads report zeros, allocations report the grant,
// the chosen hole and the size left in it, which is written back.
// cfg carries fit_policy: first, best or worst fit; the spare code is first
// fit. cfg is always ready; the user must see that cfg is written only while
// the block is idle, as the block itself does not enforce this.
//
// A load goes from the idle state straight to the finish state; an allocation
// first scans the table, one hole per cycle through the single RAM read port,
// then drains the registered read before the finish state commits. A new
// request is taken only in the idle state, after the last one has committed.
// The result sits in an output register; a new request is taken and scanned
// while it waits. If alloc_out stalls, the next result holds in its last step,
// table untouched, until the register frees up.
// Reset (rst, synchronous) empties all holes, sets first fit and drops valid.
module hole_fit_allocator_unit #(
  parameter int NUM_HOLES = hfa_pkg::NUM_HOLES_DEF,
  parameter int SIZE_BITS = hfa_pkg::SIZE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  hfa_cfg_if.sink   cfg,
  hfa_in_if.sink    alloc_in,
  hfa_out_if.source alloc_out
);
  import hfa_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  // sequencing: idle, scan, drain the last read, commit
  hfa_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  // table, compare and result registers
  hfa_datapath #(
    .NUM_HOLES (NUM_HOLES),
    .SIZE_BITS (SIZE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .alloc_in  (alloc_in),
    .alloc_out (alloc_out),
    .cfg       (cfg),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

[rtl/core/hfa_ram.sv]
// Generic single-clock RAM, one write port, one read port, registered read.
// No dependencies.
module hfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/core/hfa_ctrl.sv]
// Controller state machine of the hole fit allocator.
// Depends on hfa_pkg.
module hfa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  hfa_pkg::ctrl_stat_t stat,
  output hfa_pkg::ctrl_cmd_t  cmd
);
  import hfa_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (stat.in_valid) begin
          state_next = stat.in_alloc ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (stat.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE:   cmd.idle   = 1'b1;
      ST_SCAN:   cmd.scan   = 1'b1;
      ST_DRAIN:  cmd        = '0;
      ST_FINISH: cmd.commit = stat.out_free;
      default:   cmd        = '0;
    endcase
  end

endmodule

[rtl/core/hfa_datapath.sv]
// Datapath of the hole fit allocator: hole table, scan compare, pick
// registers, policy register and output register.
// Depends on hfa_pkg, hfa_ifs and hfa_ram.
module hfa_datapath #(
  parameter int NUM_HOLES = hfa_pkg::NUM_HOLES_DEF,
  parameter int SIZE_BITS = hfa_pkg::SIZE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  hfa_in_if.sink              alloc_in,
  hfa_out_if.source           alloc_out,
  hfa_cfg_if.sink             cfg,
  input  hfa_pkg::ctrl_cmd_t  cmd,
  output hfa_pkg::ctrl_stat_t stat
);
  import hfa_pkg::*;

  localparam int ADDR_W = $clog2(NUM_HOLES);

  logic [POLICY_BITS-1:0] policy;
  logic                   action;
  logic [INDEX_BITS-1:0]  load_idx;
  logic [SIZE_BITS-1:0]   req;
  logic [ADDR_W-1:0]      cnt;
  logic                   eval_en;
  logic [ADDR_W-1:0]      eval_idx;
  logic                   found;
  logic [ADDR_W-1:0]      pick;
  logic [SIZE_BITS-1:0]   pick_size;
  logic [NUM_HOLES-1:0]   hole_valid;
  logic                   out_valid;

  logic                   accept;
  logic [SIZE_BITS-1:0]   rd_data;
  logic [SIZE_BITS-1:0]   hole;
  logic                   hole_nz;
  logic                   hole_fits;
  logic                   take;
  logic                   grant;
  logic [SIZE_BITS-1:0]   left;
  logic                   load_ok;
  logic                   wr_en;
  logic [ADDR_W-1:0]      wr_addr;
  logic [SIZE_BITS-1:0]   wr_data;

  assign accept         = cmd.idle && alloc_in.valid;
  assign alloc_in.ready = cmd.idle;
  assign cfg.ready      = 1'b1;

  assign stat.in_valid  = alloc_in.valid;
  assign stat.in_alloc  = (alloc_in.action == ACT_ALLOC);
  assign stat.scan_last = (cnt == ADDR_W'(NUM_HOLES - 1));
  assign stat.out_free  = !out_valid || alloc_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= FIT_FIRST;
    end else if (cfg.valid) begin
      policy <= cfg.fit_policy;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      action   <= alloc_in.action;
      load_idx <= alloc_in.hole_index;
      req      <= alloc_in.size_value;
    end
  end

  // scan counter drives the table read; the compare runs in the cycle after each read is issued
  always_ff @(posedge clk) begin
    if (accept) begin
      cnt <= '0;
    end else if (cmd.scan) begin
      cnt <= cnt + 1'b1;
    end
    eval_idx <= cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eval_en <= 1'b0;
    end else begin
      eval_en <= cmd.scan;
    end
  end

  // entries never written read as empty
  assign hole      = hole_valid[eval_idx] ? rd_data : '0;
  assign hole_nz   = (hole != '0);
  assign hole_fits = hole_nz && (hole >= req);

  always_comb begin
    case (policy)
      FIT_BEST:  take = hole_fits && (!found || (hole < pick_size));
      FIT_WORST: take = hole_nz && (!found || (hole > pick_size));
      default:   take = hole_fits && !found;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (accept) begin
      found <= 1'b0;
    end else if (eval_en && take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (eval_en && take) begin
      pick      <= eval_idx;
      pick_size <= hole;
    end
  end

  // worst fit picks the largest hole first, so the fit is checked here
  assign grant   = (action == ACT_ALLOC) && found && (pick_size != '0) &&
                   (pick_size >= req);
  assign left    = pick_size - req;
  assign load_ok = (32'(load_idx) < 32'(NUM_HOLES));

  assign wr_en   = cmd.commit && ((action == ACT_ALLOC) ? grant : load_ok);
  assign wr_addr = (action == ACT_ALLOC) ? pick : ADDR_W'(load_idx);
  assign wr_data = (action == ACT_ALLOC) ? left : req;

  always_ff @(posedge clk) begin
    if (rst) begin
      hole_valid <= '0;
    end else if (wr_en) begin
      hole_valid[wr_addr] <= 1'b1;
    end
  end

  hfa_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (NUM_HOLES)
  ) u_hole_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (cnt),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (alloc_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      alloc_out.granted      <= grant;
      alloc_out.chosen_index <= grant ? INDEX_BITS'(pick) : '0;
      alloc_out.remaining    <= grant ? left : '0;
    end
  end

  assign alloc_out.valid = out_valid;

endmodule

[tb/sv/hole_fit_allocator_checker.sv]
// Scoreboard for hole_fit_allocator_unit: tracks the hole table and fit policy,
// predicts one result per request and compares it with alloc_out.
// Depends on hfa_pkg and hfa_ifs.
module hole_fit_allocator_checker (
  input  logic clk,
  input  logic rst,
  hfa_cfg_if   cfg,
  hfa_in_if    alloc_in,
  hfa_out_if   alloc_out,
  output int   outstanding,
  output int   fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import hfa_pkg::*;

  localparam int NH = NUM_HOLES_DEF;
  localparam int SB = SIZE_BITS_DEF;

  typedef struct packed {
    logic                  granted;
    logic [INDEX_BITS-1:0] chosen_index;
    logic [SB-1:0]         remaining;
  } grant_t;

  logic [SB-1:0]          hole_tbl [NH];
  logic [POLICY_BITS-1:0] policy;
  grant_t                 grant_q [$];

  // zero holes never fit, not even a zero request
  function automatic bit hole_fits(logic [SB-1:0] hole, logic [SB-1:0] req);
    return hole != '0 && hole >= req;
  endfunction

  // Applies one request to the shadow table, returns the expected result.
  function automatic grant_t fit_request(logic act, logic [INDEX_BITS-1:0] idx,
                                         logic [SB-1:0] size);
    grant_t r;
    int     pick;
    int     i;
    r    = '0;
    pick = -1;
    if (act == ACT_LOAD) begin
      if (idx < NH) hole_tbl[idx] = size;
      return r;
    end
    for (i = 0; i < NH; i++) begin
      if (policy == FIT_WORST) begin
        if (hole_tbl[i] != '0 && (pick < 0 || hole_tbl[i] > hole_tbl[pick])) pick = i;
      end else if (hole_fits(hole_tbl[i], size)) begin
        if (policy == FIT_BEST) begin
          if (pick < 0 || hole_tbl[i] < hole_tbl[pick]) pick = i;
        end else if (pick < 0) begin
          pick = i;
        end
      end
    end
    // worst fit picks the largest hole first, then checks it
    if (pick >= 0 && hole_fits(hole_tbl[pick], size)) begin
      hole_tbl[pick]  = hole_tbl[pick] - size;
      r.granted       = 1'b1;
      r.chosen_index  = pick[INDEX_BITS-1:0];
      r.remaining     = hole_tbl[pick];
    end
    return r;
  endfunction

  task automatic field_check(string name, longint unsigned want, longint unsigned got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    grant_t want;
    int     i;
    if (rst) begin
      for (i = 0; i < NH; i++) hole_tbl[i] = '0;
      policy = FIT_FIRST;
      grant_q.delete();
      fail_count = 0;
      outstanding <= 0;
    end else begin
      if (alloc_out.valid && alloc_out.ready) begin
        if (grant_q.size() == 0) begin
          $display("%0t: unexpected transaction: expected none, actual %0b/%0d/%0d",
                   $time, alloc_out.granted, alloc_out.chosen_index, alloc_out.remaining);
          fail_count++;
        end else begin
          want = grant_q.pop_front();
          field_check("granted", want.granted, alloc_out.granted);
          field_check("chosen_index", want.chosen_index, alloc_out.chosen_index);
          field_check("remaining", want.remaining, alloc_out.remaining);
        end
      end
      if (cfg.valid && cfg.ready) policy = cfg.fit_policy;
      if (alloc_in.valid && alloc_in.ready)
        grant_q.push_back(fit_request(alloc_in.action, alloc_in.hole_index,
                                      alloc_in.size_value));
      outstanding <= grant_q.size();
    end
  end

endmodule

[tb/sv/hole_fit_allocator_unit_test.sv]
// Top of the hole_fit_allocator_unit testbench: clock, reset, stimulus and verdict.
// Depends on hfa_pkg, hfa_ifs, hole_fit_allocator_unit and hole_fit_allocator_checker.
module hole_fit_allocator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hfa_pkg::*;

  localparam int SB = SIZE_BITS_DEF;
  // spare policy code, expected to behave as first fit
  localparam logic [POLICY_BITS-1:0] FIT_SPARE = 2'd3;
  localparam int PHASES     = 8;
  localparam int PHASE_ITEMS = 112;

  // alloc_out ready patterns, each picked at random by the receiver
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCKS} rx_mode_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  int       fail_count;
  int       outstanding;
  int       burst_left = 0;
  int       rx_cycle = 0;
  rx_mode_t rx_mode = RX_OPEN;

  hfa_cfg_if  cfg_ch ();
  hfa_in_if   alloc_in_ch ();
  hfa_out_if  alloc_out_ch ();

  hole_fit_allocator_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_ch),
    .alloc_in  (alloc_in_ch),
    .alloc_out (alloc_out_ch)
  );

  hole_fit_allocator_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg_ch),
    .alloc_in    (alloc_in_ch),
    .alloc_out   (alloc_out_ch),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  always #5 clk = ~clk;

  // Receiver: stall pattern of its own, independent of the sender's bursts.
  // The block pattern, ready only late in each repeating window, drifts against the table scan.
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 64 == 0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:   alloc_out_ch.ready <= 1'b1;
      RX_COIN:   alloc_out_ch.ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: alloc_out_ch.ready <= ($urandom_range(0, 3) == 0);
      default:   alloc_out_ch.ready <= (rx_cycle % 16) >= 11;
    endcase
  end

  // Sizes lean small so requests often fit, with zero and full scale mixed in.
  function automatic logic [SB-1:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return SB'($urandom_range(0, (1 << SB) - 1));
      default: return SB'($urandom_range(0, 4095));
    endcase
  endfunction

  // One transaction on alloc_in. Valid stays high across a burst; between
  // bursts it drops for a random gap (sometimes none). Returns right after
  // the accepting edge, valid still high.
  task automatic send_item(logic act, logic [INDEX_BITS-1:0] idx, logic [SB-1:0] size);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        alloc_in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    alloc_in_ch.valid      <= 1'b1;
    alloc_in_ch.action     <= act;
    alloc_in_ch.hole_index <= idx;
    alloc_in_ch.size_value <= size;
    do @(posedge clk); while (!alloc_in_ch.ready);
  endtask

  // Policy write: only once every result has drained and the block is idle.
  // Each request yields a result, so an empty scoreboard means idle.
  task automatic set_policy(logic [POLICY_BITS-1:0] pol);
    alloc_in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (outstanding != 0);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.fit_policy <= pol;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    logic [POLICY_BITS-1:0] sweep [4];
    int                     ph;
    int                     n;
    sweep = '{FIT_FIRST, FIT_BEST, FIT_WORST, FIT_SPARE};

    cfg_ch.valid           = 1'b0;
    cfg_ch.fit_policy      = FIT_FIRST;
    alloc_in_ch.valid      = 1'b0;
    alloc_in_ch.action     = ACT_LOAD;
    alloc_in_ch.hole_index = '0;
    alloc_in_ch.size_value = '0;
    alloc_out_ch.ready     = 1'b0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: first fit from reset policy
    send_item(ACT_ALLOC, 3'd0, 16'd5);       // empty table, no fit
    send_item(ACT_ALLOC, 3'd0, 16'd0);       // zero request vs zero holes
    send_item(ACT_LOAD,  3'd0, 16'd100);
    send_item(ACT_LOAD,  3'd1, 16'hFFFF);
    send_item(ACT_LOAD,  3'd7, 16'd100);
    send_item(ACT_LOAD,  3'd3, 16'd50);
    send_item(ACT_ALLOC, 3'd7, 16'd100);     // exact fit, hole 0 drops to zero
    send_item(ACT_ALLOC, 3'd0, 16'd0);       // zero request keeps hole 1 full
    send_item(ACT_ALLOC, 3'd0, 16'hFFFF);    // full-scale request drains hole 1
    send_item(ACT_ALLOC, 3'd0, 16'hFFFF);    // nothing left that big
    // best fit: tie between holes 2 and 5 goes to 2
    set_policy(FIT_BEST);
    send_item(ACT_LOAD,  3'd2, 16'd40);
    send_item(ACT_LOAD,  3'd5, 16'd40);
    send_item(ACT_LOAD,  3'd6, 16'd500);
    send_item(ACT_ALLOC, 3'd0, 16'd30);
    send_item(ACT_ALLOC, 3'd0, 16'd60);
    // worst fit: largest hole too small means no grant
    set_policy(FIT_WORST);
    send_item(ACT_ALLOC, 3'd0, 16'd1000);
    send_item(ACT_ALLOC, 3'd0, 16'd500);
    send_item(ACT_ALLOC, 3'd0, 16'd0);
    // spare code acts as first fit
    set_policy(FIT_SPARE);
    send_item(ACT_ALLOC, 3'd0, 16'd45);
    send_item(ACT_LOAD,  3'd4, 16'hFFFF);

    // Random phases: each starts by refilling every hole, then mixes loads
    // and requests. First sweep all policy codes, then random ones.
    for (ph = 0; ph < PHASES; ph++) begin
      set_policy(ph < 4 ? sweep[ph] : POLICY_BITS'($urandom_range(0, 3)));
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n < NUM_HOLES_DEF)
          send_item(ACT_LOAD, n[INDEX_BITS-1:0], pick_size());
        else if ($urandom_range(0, 99) < 35)
          send_item(ACT_LOAD, INDEX_BITS'($urandom), pick_size());
        else
          send_item(ACT_ALLOC, INDEX_BITS'($urandom), pick_size() >> $urandom_range(0, 3));
      end
    end

    alloc_in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (NUM_HOLES_DEF + 4) @(posedge clk);
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

[sim.f]
rtl/core/hfa_pkg.sv
rtl/core/hfa_ifs.sv
rtl/core/hfa_ram.sv
rtl/core/hfa_ctrl.sv
rtl/core/hfa_datapath.sv
rtl/core/hole_fit_allocator_unit.sv
tb/sv/hole_fit_allocator_checker.sv
tb/sv/hole_fit_allocator_unit_test.sv
